// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the clock-setting menu.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/csm_pkg.sv -----
// Shared types, codes and field limits of the clock-setting menu.
package csm_pkg;

   // Item kinds on the request channel
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Key codes; codes above KEY_NEXT behave as no key
   localparam logic [2:0] KEY_NONE = 3'd0;
   localparam logic [2:0] KEY_MODE = 3'd1;
   localparam logic [2:0] KEY_UP   = 3'd2;
   localparam logic [2:0] KEY_DOWN = 3'd3;
   localparam logic [2:0] KEY_NEXT = 3'd4;

   // Field limits
   localparam logic [7:0] YEAR_SPAN   = 8'd100;
   localparam logic [6:0] YEAR_TOP    = 7'd99;
   localparam logic [3:0] MONTH_TOP   = 4'd12;
   localparam logic [4:0] DATE_TOP    = 5'd31;
   localparam logic [2:0] WEEKDAY_TOP = 3'd7;
   localparam logic [3:0] HOUR_TOP    = 4'd12;
   localparam logic [6:0] MINSEC_SPAN = 7'd60;
   localparam logic [5:0] MINSEC_TOP  = 6'd59;

   // Calendar copy
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] date;
      logic [2:0] weekday;
      logic [3:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       pm;
   } cal_type;

   localparam cal_type CAL_RESET = '{
      year: 7'd0, month: 4'd1, date: 5'd1, weekday: 3'd1,
      hour: 4'd12, minute: 6'd0, second: 6'd0, pm: 1'b0
   };

   // One request item
   typedef struct packed {
      logic       req_type;
      logic [2:0] key;
      cal_type    cal;
   } item_type;

   // One result item
   typedef struct packed {
      logic [3:0] menu_mode;
      cal_type    cal;
      logic       write_clock;
      logic       display_reset;
   } result_type;

endpackage

// ----- rtl/csm_menu.sv -----
// Menu state, calendar copy and the key/load update logic of the clock-setting menu.
module csm_menu (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  csm_pkg::item_type   item,
   output csm_pkg::result_type result
);

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_YEAR    = 4'd1,
      MODE_MONTH   = 4'd2,
      MODE_DATE    = 4'd3,
      MODE_WEEKDAY = 4'd4,
      MODE_HOUR    = 4'd5,
      MODE_MINUTE  = 4'd6,
      MODE_SECOND  = 4'd7,
      MODE_AMPM    = 4'd8,
      MODE_INIT    = 4'd9
   } mode_type;

   mode_type         mode_ff, mode_in;
   mode_type         last_mode_ff, last_mode_in;
   csm_pkg::cal_type cal_ff, cal_in;
   logic             write_clock, display_reset, key_up;

   logic [7:0] year_inc;
   logic [6:0] year_up, year_dn;
   logic [3:0] month_up, month_dn, hour_up, hour_dn;
   logic [4:0] date_up, date_dn;
   logic [2:0] weekday_up, weekday_dn;
   logic [6:0] minute_inc, second_inc;
   logic [5:0] minute_up, minute_dn, second_up;

   // Field order for NEXT: weekday, date, month, year, hour, minute, second, am/pm
   function automatic mode_type next_field(input mode_type m);
      mode_type n;
      unique case (m)
         MODE_WEEKDAY: n = MODE_DATE;
         MODE_DATE:    n = MODE_MONTH;
         MODE_MONTH:   n = MODE_YEAR;
         MODE_YEAR:    n = MODE_HOUR;
         MODE_HOUR:    n = MODE_MINUTE;
         MODE_MINUTE:  n = MODE_SECOND;
         MODE_SECOND:  n = MODE_AMPM;
         default:      n = MODE_WEEKDAY;
      endcase
      return n;
   endfunction

   // Wrapped up and down values of year, month, date, weekday, hour and minute; up value of second
   always_comb begin
      year_inc   = {1'b0, cal_ff.year} + 8'd1;
      year_up    = (year_inc >= csm_pkg::YEAR_SPAN) ? 7'(year_inc - csm_pkg::YEAR_SPAN)
                                                    : year_inc[6:0];
      year_dn    = (cal_ff.year == 7'd0) ? csm_pkg::YEAR_TOP : cal_ff.year - 7'd1;

      month_up   = ((cal_ff.month >= csm_pkg::MONTH_TOP) ? cal_ff.month - csm_pkg::MONTH_TOP
                                                         : cal_ff.month) + 4'd1;
      month_dn   = (cal_ff.month <= 4'd1) ? csm_pkg::MONTH_TOP : cal_ff.month - 4'd1;

      date_up    = ((cal_ff.date == csm_pkg::DATE_TOP) ? 5'd0 : cal_ff.date) + 5'd1;
      date_dn    = (cal_ff.date <= 5'd1) ? csm_pkg::DATE_TOP : cal_ff.date - 5'd1;

      weekday_up = ((cal_ff.weekday == csm_pkg::WEEKDAY_TOP) ? 3'd0 : cal_ff.weekday) + 3'd1;
      weekday_dn = (cal_ff.weekday <= 3'd1) ? csm_pkg::WEEKDAY_TOP : cal_ff.weekday - 3'd1;

      hour_up    = ((cal_ff.hour >= csm_pkg::HOUR_TOP) ? cal_ff.hour - csm_pkg::HOUR_TOP
                                                       : cal_ff.hour) + 4'd1;
      hour_dn    = (cal_ff.hour <= 4'd1) ? csm_pkg::HOUR_TOP : cal_ff.hour - 4'd1;

      minute_inc = {1'b0, cal_ff.minute} + 7'd1;
      minute_up  = (minute_inc >= csm_pkg::MINSEC_SPAN)
                   ? 6'(minute_inc - csm_pkg::MINSEC_SPAN) : minute_inc[5:0];
      minute_dn  = (cal_ff.minute == 6'd0) ? csm_pkg::MINSEC_TOP : cal_ff.minute - 6'd1;

      second_inc = {1'b0, cal_ff.second} + 7'd1;
      second_up  = (second_inc >= csm_pkg::MINSEC_SPAN)
                   ? 6'(second_inc - csm_pkg::MINSEC_SPAN) : second_inc[5:0];
   end

   // Next menu state and calendar for the current item
   always_comb begin
      mode_in       = mode_ff;
      last_mode_in  = last_mode_ff;
      cal_in        = cal_ff;
      write_clock   = 1'b0;
      display_reset = 1'b0;
      key_up        = (item.key == csm_pkg::KEY_UP);

      if (item.req_type == csm_pkg::REQ_LOAD) begin
         cal_in = item.cal;
      end else begin
         case (item.key) inside
            csm_pkg::KEY_MODE, csm_pkg::KEY_UP, csm_pkg::KEY_DOWN, csm_pkg::KEY_NEXT: begin
               display_reset = 1'b1;
            end
            default: begin
               display_reset = 1'b0;
            end
         endcase

         unique case (mode_ff) inside
            MODE_IDLE: begin
               if (item.key == csm_pkg::KEY_MODE) begin
                  mode_in      = (last_mode_ff == MODE_IDLE) ? MODE_WEEKDAY : last_mode_ff;
                  last_mode_in = mode_in;
               end else if (item.key == csm_pkg::KEY_NEXT) begin
                  cal_in.second = '0;
                  write_clock   = 1'b1;
               end
            end
            MODE_YEAR, MODE_MONTH, MODE_DATE, MODE_WEEKDAY, MODE_HOUR, MODE_MINUTE,
            MODE_SECOND, MODE_AMPM: begin
               case (item.key) inside
                  csm_pkg::KEY_MODE: begin
                     last_mode_in = mode_ff;
                     mode_in      = MODE_IDLE;
                  end
                  csm_pkg::KEY_NEXT: begin
                     last_mode_in = mode_ff;
                     mode_in      = next_field(mode_ff);
                  end
                  csm_pkg::KEY_UP, csm_pkg::KEY_DOWN: begin
                     write_clock = 1'b1;
                     unique case (mode_ff)
                        MODE_YEAR:    cal_in.year    = key_up ? year_up    : year_dn;
                        MODE_MONTH:   cal_in.month   = key_up ? month_up   : month_dn;
                        MODE_DATE:    cal_in.date    = key_up ? date_up    : date_dn;
                        MODE_WEEKDAY: cal_in.weekday = key_up ? weekday_up : weekday_dn;
                        MODE_HOUR:    cal_in.hour    = key_up ? hour_up    : hour_dn;
                        MODE_MINUTE:  cal_in.minute  = key_up ? minute_up  : minute_dn;
                        MODE_SECOND:  cal_in.second  = key_up ? second_up  : 6'd0;
                        default:      cal_in.pm      = ~cal_ff.pm;
                     endcase
                  end
                  default: begin
                     write_clock = 1'b0;
                  end
               endcase
            end
            default: begin
               // init, and any code that cannot arise
               mode_in      = MODE_IDLE;
               last_mode_in = MODE_WEEKDAY;
            end
         endcase
      end
   end

   // Hold state; advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INIT;
         last_mode_ff <= MODE_WEEKDAY;
         cal_ff       <= csm_pkg::CAL_RESET;
      end else if (advance) begin
         mode_ff      <= mode_in;
         last_mode_ff <= last_mode_in;
         cal_ff       <= cal_in;
      end
   end

   assign result.menu_mode     = mode_in;
   assign result.cal           = cal_in;
   assign result.write_clock   = write_clock;
   assign result.display_reset = display_reset;

endmodule

// ----- rtl/clock_set_menu_fsm.sv -----
// Top level of the clock-setting menu: request/response handshake and result register.
//
// Request channel (req_*): either a key event (req_type 0, req_key) or a load of
// the time read from the clock (req_type 1, req_load_*). Response channel (rsp_*):
// one result per request, carrying the menu mode after the step, the calendar copy,
// and the write_clock and display_reset strobes for that step.
// Both channels use valid/ready; a transfer happens when both are high.
// A result is registered and appears on rsp_* the cycle after its request transfer.
// Throughput: one request per cycle unless rsp_* stalls. The menu update is a single pass
// of compare and wrap logic on the state registers, and the result register sits behind it.
// A new request is taken whenever the result register is empty or being drained
// in the same cycle, so a stalled receiver stalls the request side after one item.
// Reset (synchronous, active high): menu mode init, last edited field weekday,
// calendar 00 year, month 1, date 1, weekday 1, 12:00:00 am, response empty;
// req_ready stays low while reset is high.
`include "assert_macros.svh"

module clock_set_menu_fsm (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [2:0] req_key,
   input  logic [6:0] req_load_year,
   input  logic [3:0] req_load_month,
   input  logic [4:0] req_load_date,
   input  logic [2:0] req_load_weekday,
   input  logic [3:0] req_load_hour,
   input  logic [5:0] req_load_minute,
   input  logic [5:0] req_load_second,
   input  logic       req_load_pm,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_menu_mode,
   output logic [6:0] rsp_year_out,
   output logic [3:0] rsp_month_out,
   output logic [4:0] rsp_date_out,
   output logic [2:0] rsp_weekday_out,
   output logic [3:0] rsp_hour_out,
   output logic [5:0] rsp_minute_out,
   output logic [5:0] rsp_second_out,
   output logic       rsp_pm_out,
   output logic       rsp_write_clock,
   output logic       rsp_display_reset
);

   csm_pkg::item_type   item;
   csm_pkg::result_type result;
   csm_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_fire;
   logic                load_fire;

   // Gather the request fields
   assign item.req_type    = req_type;
   assign item.key         = req_key;
   assign item.cal.year    = req_load_year;
   assign item.cal.month   = req_load_month;
   assign item.cal.date    = req_load_date;
   assign item.cal.weekday = req_load_weekday;
   assign item.cal.hour    = req_load_hour;
   assign item.cal.minute  = req_load_minute;
   assign item.cal.second  = req_load_second;
   assign item.cal.pm      = req_load_pm;

   // Accept when the result register is empty or drains this cycle
   assign req_ready = ~reset & (~rsp_valid_ff | rsp_ready);
   assign req_fire  = req_valid & req_ready;
   assign load_fire = req_fire & (req_type == csm_pkg::REQ_LOAD);

   csm_menu u_menu (
      .clock   (clock),
      .reset   (reset),
      .advance (req_fire),
      .item    (item),
      .result  (result)
   );

   // Result register
   assign rsp_valid_in = req_fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   // Drive the response ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_menu_mode     = rsp_ff.menu_mode;
   assign rsp_year_out      = rsp_ff.cal.year;
   assign rsp_month_out     = rsp_ff.cal.month;
   assign rsp_date_out      = rsp_ff.cal.date;
   assign rsp_weekday_out   = rsp_ff.cal.weekday;
   assign rsp_hour_out      = rsp_ff.cal.hour;
   assign rsp_minute_out    = rsp_ff.cal.minute;
   assign rsp_second_out    = rsp_ff.cal.second;
   assign rsp_pm_out        = rsp_ff.cal.pm;
   assign rsp_write_clock   = rsp_ff.write_clock;
   assign rsp_display_reset = rsp_ff.display_reset;

   // A waiting result blocks new requests
   `ASSERT_IMP(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready)
   // Every transfer leaves a result behind
   `ASSERT_NXT(a_result_follows, clock, reset, req_fire, rsp_valid_ff)
   // A load never raises a strobe
   `ASSERT_NXT(a_load_quiet, clock, reset, load_fire, !rsp_write_clock && !rsp_display_reset)
   // Every clock write comes from a key
   `ASSERT_IMP(a_write_from_key, clock, reset, rsp_valid_ff && rsp_write_clock, rsp_display_reset)

endmodule
